[src/oaids_pkg.sv]
// Shared widths, operation codes and status codes for the ordered array block.
package oaids_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 3;
    localparam int IDX_W  = 4;
    localparam int TDATA_W = 40;

    typedef logic [OP_W-1:0]  t_op;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [VAL_W-1:0] t_word;

    localparam t_op OP_CLEAR   = 3'd0;
    localparam t_op OP_APPEND  = 3'd1;
    localparam t_op OP_READOUT = 3'd2;
    localparam t_op OP_INSERT  = 3'd3;
    localparam t_op OP_DELETE  = 3'd4;
    localparam t_op OP_SEARCH  = 3'd5;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_FULL     = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_BADPOS   = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;

endpackage

[src/ordered_array_insert_delete_search.sv]
// Top level: bounded ordered word list with insert, delete, search and read-out.
//
//  port group   dir   tdata (low bit up)              tuser        tlast
//  s_axis       in    position[4:0], value[36:5]      operation    -
//  m_axis       out   index[3:0], data[35:4]          status       last of request
//
//  Clear, append and rejected requests go straight to the result register.
//  Insert shifts the entries from position upward up by one, then writes the value;
//  delete shifts later entries down by one. Search compares in order; read-out emits each.
//  Each step reads the single-port-read entry RAM, then writes, compares or emits.
//  Reset is synchronous, active low; it empties the list. A stalled m_axis holds the
//  sequencer at its emit step; a new request is taken only while the sequencer is idle.
module ordered_array_insert_delete_search #(
    parameter int CAPACITY = oaids_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [oaids_pkg::TDATA_W-1:0] s_axis_tdata,  // position[4:0], value[36:5]
    input  logic [oaids_pkg::OP_W-1:0]   s_axis_tuser,  // operation[2:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [oaids_pkg::TDATA_W-1:0] m_axis_tdata,  // index[3:0], data[35:4]
    output logic [oaids_pkg::ST_W-1:0]   m_axis_tuser,  // status[2:0]
    output logic                         m_axis_tlast
);
    import oaids_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RESP   = 4'd1;
    localparam logic [3:0] S_RD_REQ = 4'd2;
    localparam logic [3:0] S_RD_OUT = 4'd3;
    localparam logic [3:0] S_INS_RD = 4'd4;
    localparam logic [3:0] S_INS_WR = 4'd5;
    localparam logic [3:0] S_DEL_RD = 4'd6;
    localparam logic [3:0] S_DEL_WR = 4'd7;
    localparam logic [3:0] S_SR_RD  = 4'd8;
    localparam logic [3:0] S_SR_CMP = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_pos, n_pos;
    t_word            r_val, n_val;
    t_status          r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_index, n_res_index;

    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_index, n_out_index;
    t_word            r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    t_word            ram_wdata, ram_rdata;

    logic             w_accept, w_can_load, w_full;
    t_op              w_op;
    logic [PW-1:0]    w_pos, w_cnt;
    t_word            w_val;

    oaids_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_pos         = PW'(s_axis_tdata[POS_W-1:0]);
    assign w_val         = s_axis_tdata[POS_W +: VAL_W];
    assign w_cnt         = PW'(r_count);
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_can_load    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_idx[AW-1:0];
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val        = w_val;
                    n_pos        = w_pos[AW-1:0];
                    n_res_status = ST_OK;
                    n_res_index  = '0;
                    n_state      = S_RESP;
                    unique case (w_op)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = w_val;
                                n_count   = CW'(r_count + 1'b1);
                            end
                        end
                        OP_READOUT: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RD_REQ;
                            end
                        end
                        OP_INSERT: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else if (w_pos > w_cnt) begin
                                n_res_status = ST_BADPOS;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (w_pos >= w_cnt) begin
                                n_res_status = ST_BADPOS;
                            end else begin
                                n_idx   = CW'(w_pos);
                                n_state = S_DEL_RD;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SR_RD;
                            end
                        end
                        default: begin
                            // unused codes give no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (w_can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_out_data   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD_REQ: begin
                ram_re  = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (w_can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_index  = IDX_W'(r_idx);
                    n_out_data   = ram_rdata;
                    n_out_last   = (CW'(r_idx + 1'b1) == r_count);
                    n_idx        = CW'(r_idx + 1'b1);
                    n_state      = n_out_last ? S_IDLE : S_RD_REQ;
                end
            end
            S_INS_RD: begin
                if (r_idx > CW'(r_pos)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx - 1'b1);
                    n_state   = S_INS_WR;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_val;
                    n_count   = CW'(r_count + 1'b1);
                    n_state   = S_RESP;
                end
            end
            S_INS_WR: begin
                // move entry idx-1 up into idx
                ram_we  = 1'b1;
                n_idx   = CW'(r_idx - 1'b1);
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (CW'(r_idx + 1'b1) < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + 1'b1);
                    n_state   = S_DEL_WR;
                end else begin
                    n_count = CW'(r_count - 1'b1);
                    n_state = S_RESP;
                end
            end
            S_DEL_WR: begin
                ram_we  = 1'b1;
                n_idx   = CW'(r_idx + 1'b1);
                n_state = S_DEL_RD;
            end
            S_SR_RD: begin
                if (r_idx < r_count) begin
                    ram_re  = 1'b1;
                    n_state = S_SR_CMP;
                end else begin
                    n_res_status = ST_NOTFOUND;
                    n_state      = S_RESP;
                end
            end
            S_SR_CMP: begin
                if (ram_rdata == r_val) begin
                    n_res_index = IDX_W'(r_idx);
                    n_state     = S_RESP;
                end else begin
                    n_idx   = CW'(r_idx + 1'b1);
                    n_state = S_SR_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_data, r_out_index});
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

[src/oaids_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oaids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/oaids_chk.sv]
// Port-level checker for the ordered array block, bound to the top level.
module oaids_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [oaids_pkg::TDATA_W-1:0] s_axis_tdata,
    input logic [oaids_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [oaids_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [oaids_pkg::ST_W-1:0]    m_axis_tuser,
    input logic                          m_axis_tlast
);
    import oaids_pkg::*;

    // held result must not change under backpressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // only read-out carries data; every other status is a single zero-payload result
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("non-ok result not final or has payload");

    // a real operation keeps the block busy for at least the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser <= OP_SEARCH |=> !s_axis_tready)
        else $error("request accepted back to back");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind ordered_array_insert_delete_search oaids_chk u_oaids_chk (.*);
